/* src/srrq_pkg.sv */
`default_nettype none
package srrq_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_BYTES = 8;
    localparam logic [63:0] KEY_MASK = ~({64{1'b1}} >> (8 * KEY_BYTES));

    localparam int IN_W = 360;
    localparam int OUT_W = 168;

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_MAX = 3'd2;
    localparam logic [2:0] OP_MIN = 3'd3;
    localparam logic [2:0] OP_SUM = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [47:0] PRICE_MAX = {48{1'b1}};
    localparam logic [62:0] CAP_MAX = {63{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_EVAL,
        S_FINISH,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        RES_OK,
        RES_FULL,
        RES_NONE,
        RES_QUERY
    } res_sel_t;

    typedef struct packed {
        logic [63:0] date_key;
        logic [63:0] currency_key;
        logic [63:0] exchange_key;
        logic [47:0] low_price;
        logic [47:0] high_price;
        logic [62:0] capitalisation;
    } rec_t;

    typedef struct packed {
        logic     latch;
        logic     write_rec;
        logic     rd_en;
        logic     eval;
        logic     idx_inc;
        logic     res_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       last;
        logic       hit;
    } stat_t;

endpackage
`default_nettype wire

/* src/srrq_ctrl.sv */
`default_nettype none
module srrq_ctrl
    import srrq_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                if ((stat.op == OP_LOOKUP || stat.op == OP_MAX || stat.op == OP_MIN
                     || stat.op == OP_SUM) && !stat.empty) begin
                    state_next = S_READ;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_READ: state_next = S_EVAL;
            S_EVAL: begin
                if ((stat.hit && stat.op == OP_LOOKUP) || stat.last) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_READ;
                end
            end
            S_FINISH: state_next = S_OUT;
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.res_sel = RES_NONE;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.latch = s_tvalid;
            end
            S_DISPATCH: begin
                if (stat.op == OP_LOAD) begin
                    cmd.res_load = 1'b1;
                    if (stat.full) begin
                        cmd.res_sel = RES_FULL;
                    end else begin
                        cmd.res_sel = RES_OK;
                        cmd.write_rec = 1'b1;
                    end
                end else if ((stat.op == OP_LOOKUP || stat.op == OP_MAX
                              || stat.op == OP_MIN || stat.op == OP_SUM) && !stat.empty) begin
                    cmd.res_load = 1'b0;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel = RES_NONE;
                end
            end
            S_READ: cmd.rd_en = 1'b1;
            S_EVAL: begin
                cmd.eval = 1'b1;
                cmd.idx_inc = !((stat.hit && stat.op == OP_LOOKUP) || stat.last);
            end
            S_FINISH: begin
                cmd.res_load = 1'b1;
                cmd.res_sel = RES_QUERY;
            end
            S_OUT: m_tvalid = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* src/srrq_dp.sv */
`default_nettype none
module srrq_dp
    import srrq_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire cmd_t             cmd,
    output stat_t                 stat,
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    rec_t mem [TABLE_DEPTH];
    rec_t rd_data_reg;
    rec_t key_reg;
    logic [2:0] op_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg;
    logic found_reg;
    logic sat_reg;
    logic [47:0] best_reg;
    logic [47:0] lo_reg;
    logic [47:0] hi_reg;
    logic [62:0] cap_reg;
    logic [62:0] total_reg;
    logic [63:0] sum_next;
    logic match_triple, match_cur, match_exch, match;
    logic [1:0] o_status_reg, o_status_next;
    logic [47:0] o_first_reg, o_second_reg;
    logic [47:0] o_first_next, o_second_next;
    logic [62:0] o_amount_reg, o_amount_next;
    logic o_sat_reg, o_sat_next;

    assign match_triple = rd_data_reg.date_key == key_reg.date_key
                       && rd_data_reg.currency_key == key_reg.currency_key
                       && rd_data_reg.exchange_key == key_reg.exchange_key;
    assign match_cur = rd_data_reg.date_key == key_reg.date_key
                    && rd_data_reg.currency_key == key_reg.currency_key;
    assign match_exch = rd_data_reg.date_key == key_reg.date_key
                     && rd_data_reg.exchange_key == key_reg.exchange_key;

    always_comb begin
        case (op_reg)
            OP_LOOKUP: match = match_triple;
            OP_MAX, OP_MIN: match = match_cur;
            OP_SUM: match = match_exch;
            default: match = 1'b0;
        endcase
    end

    assign sum_next = {1'b0, total_reg} + {1'b0, rd_data_reg.capitalisation};

    assign stat.op = op_reg;
    assign stat.full = count_reg == CNT_W'(TABLE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign stat.last = idx_reg == IDX_W'(count_reg - CNT_W'(1));
    assign stat.hit = match;

    // field packing of the input word
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg <= s_tdata[2:0];
            key_reg.date_key <= s_tdata[66:3] & KEY_MASK;
            key_reg.currency_key <= s_tdata[130:67] & KEY_MASK;
            key_reg.exchange_key <= s_tdata[194:131] & KEY_MASK;
            key_reg.low_price <= s_tdata[242:195];
            key_reg.high_price <= s_tdata[290:243];
            key_reg.capitalisation <= s_tdata[353:291];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_rec) mem[count_reg[IDX_W-1:0]] <= key_reg;
        if (cmd.rd_en) rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            sat_reg <= 1'b0;
        end else begin
            if (cmd.write_rec) count_reg <= count_reg + CNT_W'(1);
            if (cmd.latch) begin
                idx_reg <= '0;
                found_reg <= 1'b0;
                sat_reg <= 1'b0;
            end else if (cmd.eval) begin
                if (cmd.idx_inc) idx_reg <= idx_reg + IDX_W'(1);
                if (match) begin
                    found_reg <= 1'b1;
                    if (op_reg == OP_SUM && sum_next[63]) sat_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            best_reg <= (s_tdata[2:0] == OP_MIN) ? PRICE_MAX : '0;
            total_reg <= '0;
        end else if (cmd.eval && match) begin
            case (op_reg)
                OP_LOOKUP: begin
                    lo_reg <= rd_data_reg.low_price;
                    hi_reg <= rd_data_reg.high_price;
                    cap_reg <= rd_data_reg.capitalisation;
                end
                OP_MAX: begin
                    if (rd_data_reg.high_price > best_reg) best_reg <= rd_data_reg.high_price;
                end
                OP_MIN: begin
                    if (rd_data_reg.low_price < best_reg) best_reg <= rd_data_reg.low_price;
                end
                OP_SUM: total_reg <= sum_next[63] ? CAP_MAX : sum_next[62:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_status_next = ST_NONE;
        o_first_next = '0;
        o_second_next = '0;
        o_amount_next = '0;
        o_sat_next = 1'b0;
        case (cmd.res_sel)
            RES_OK: o_status_next = ST_OK;
            RES_FULL: o_status_next = ST_FULL;
            RES_QUERY: begin
                if (found_reg) begin
                    o_status_next = ST_OK;
                    case (op_reg)
                        OP_LOOKUP: begin
                            o_first_next = lo_reg;
                            o_second_next = hi_reg;
                            o_amount_next = cap_reg;
                        end
                        OP_MAX, OP_MIN: o_first_next = best_reg;
                        OP_SUM: begin
                            o_amount_next = total_reg;
                            o_sat_next = sat_reg;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            o_status_reg <= o_status_next;
            o_first_reg <= o_first_next;
            o_second_reg <= o_second_next;
            o_amount_reg <= o_amount_next;
            o_sat_reg <= o_sat_next;
        end
    end

    assign m_tdata = {6'd0, o_sat_reg, o_amount_reg, o_second_reg, o_first_reg, o_status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("record count past table depth");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) || ({1'b0, idx_reg} < (IDX_W + 1)'(count_reg)))
        else $error("scan index past record count");

    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_rec |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("load did not bump record count");

endmodule
`default_nettype wire

/* src/sorted_record_range_query_core.sv */
`default_nettype none
// channel   dir  handshake            tdata fields (lsb up)
// s_        in   s_tvalid, s_tready   opcode, date_key, currency_key, exchange_key,
//                                     low_price, high_price, capitalisation
// m_        out  m_tvalid, m_tready   status, price_first, price_second, amount,
//                                     sum_saturated
//
// one word at a time: a load passes IDLE, DISPATCH, OUT; a query passes IDLE, DISPATCH,
// READ then EVAL per record scanned (single read port, read then compare), FINISH, OUT
// a lookup stops at its first hit, the other queries scan every record
// aresetn clears the record count; record memory holds no reset
// the result is held on m_ until taken, no new word is taken meanwhile
module sorted_record_range_query_core
    import srrq_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // opcode, date_key, currency_key, exchange_key, low_price, high_price, capitalisation
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // status, price_first, price_second, amount, sum_saturated
    output logic [OUT_W-1:0]      m_tdata
);

    cmd_t  cmd;
    stat_t stat;

    srrq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srrq_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire

/* tb/sorted_record_range_query_core_test.sv */
`timescale 1ns / 1ps
module sorted_record_range_query_core_test;
    import srrq_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 6000000;
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam logic [63:0] K0 = 64'h0;
    localparam logic [63:0] K1 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KA = 64'h3230_3137_3031_3032;
    localparam logic [63:0] KB = 64'h5553_4400_0000_0000;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] price_first;
        logic [47:0] price_second;
        logic [62:0] amount;
        logic        sum_saturated;
    } quote_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] date_key;
        logic [63:0] currency_key;
        logic [63:0] exchange_key;
        logic [47:0] low_price;
        logic [47:0] high_price;
        logic [62:0] capitalisation;
        logic        fixed;
        quote_t      known;
    } order_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    // opcode, date_key, currency_key, exchange_key, low_price, high_price, capitalisation
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // status, price_first, price_second, amount, sum_saturated
    logic [OUT_W-1:0]  m_tdata;

    sorted_record_range_query_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // records kept in load order: the first equal triple is the earliest load
    logic [63:0] rec_date [DEPTH];
    logic [63:0] rec_cur [DEPTH];
    logic [63:0] rec_exch [DEPTH];
    logic [47:0] rec_lo [DEPTH];
    logic [47:0] rec_hi [DEPTH];
    logic [62:0] rec_cap [DEPTH];
    int          rec_count = 0;

    quote_t      pending_quotes[$];
    logic [63:0] key_pool [4];
    int          errors = 0;
    int          checked = 0;
    int          cycles = 0;
    int          loads_sent = 0;
    int          queries_sent = 0;
    int          burst_left = 0;
    int          long_hold = 0;
    int          n_saturated = 0;
    int          n_full = 0;
    bit          done = 0;

    always #10 aclk = ~aclk;

    function automatic quote_t apply_order(input order_t it);
        quote_t      q;
        logic [63:0] d, c, e;
        logic [63:0] total;
        logic [47:0] best;
        bit          hit;
        q = '0;
        q.status = ST_NONE;
        d = it.date_key & KEY_MASK;
        c = it.currency_key & KEY_MASK;
        e = it.exchange_key & KEY_MASK;
        hit = 0;
        total = 0;
        case (it.op)
            OP_LOAD: begin
                if (rec_count >= DEPTH) begin
                    q.status = ST_FULL;
                end else begin
                    rec_date[rec_count] = d;
                    rec_cur[rec_count] = c;
                    rec_exch[rec_count] = e;
                    rec_lo[rec_count] = it.low_price;
                    rec_hi[rec_count] = it.high_price;
                    rec_cap[rec_count] = it.capitalisation;
                    rec_count++;
                    q.status = ST_OK;
                end
            end
            OP_LOOKUP: begin
                for (int i = 0; i < rec_count && !hit; i++) begin
                    if (rec_date[i] == d && rec_cur[i] == c && rec_exch[i] == e) begin
                        hit = 1;
                        q.status = ST_OK;
                        q.price_first = rec_lo[i];
                        q.price_second = rec_hi[i];
                        q.amount = rec_cap[i];
                    end
                end
            end
            OP_MAX, OP_MIN: begin
                best = (it.op == OP_MAX) ? '0 : PRICE_MAX;
                for (int i = 0; i < rec_count; i++) begin
                    if (rec_date[i] == d && rec_cur[i] == c) begin
                        hit = 1;
                        if (it.op == OP_MAX && rec_hi[i] > best) best = rec_hi[i];
                        if (it.op == OP_MIN && rec_lo[i] < best) best = rec_lo[i];
                    end
                end
                if (hit) begin
                    q.status = ST_OK;
                    q.price_first = best;
                end
            end
            OP_SUM: begin
                // saturating sum of non-negative terms does not depend on order
                for (int i = 0; i < rec_count; i++) begin
                    if (rec_date[i] == d && rec_exch[i] == e) begin
                        hit = 1;
                        total = total + {1'b0, rec_cap[i]};
                        if (total > {1'b0, CAP_MAX}) begin
                            total = {1'b0, CAP_MAX};
                            q.sum_saturated = 1'b1;
                        end
                    end
                end
                if (hit) begin
                    q.status = ST_OK;
                    q.amount = total[62:0];
                end
            end
            default: ;
        endcase
        return q;
    endfunction

    function automatic logic [63:0] pick_key();
        if ($urandom_range(0, 15) == 0) return {$urandom, $urandom};
        return key_pool[$urandom_range(0, 3)];
    endfunction

    function automatic order_t random_order(input logic [2:0] op);
        order_t it;
        it = '0;
        it.op = op;
        it.date_key = pick_key();
        it.currency_key = pick_key();
        it.exchange_key = pick_key();
        case ($urandom_range(0, 7))
            0: it.low_price = '0;
            1: it.low_price = PRICE_MAX;
            default: it.low_price = 48'({$urandom, $urandom});
        endcase
        case ($urandom_range(0, 7))
            0: it.high_price = '0;
            1: it.high_price = PRICE_MAX;
            default: it.high_price = 48'({$urandom, $urandom});
        endcase
        if ($urandom_range(0, 1) == 0) it.capitalisation = 63'({$urandom, $urandom});
        else it.capitalisation = 63'($urandom_range(0, 1000));
        if ($urandom_range(0, 31) == 0) it.capitalisation = CAP_MAX;
        return it;
    endfunction

    function automatic logic [2:0] random_query_op();
        if ($urandom_range(0, 49) == 0) return 3'($urandom_range(5, 7));
        return 3'($urandom_range(1, 4));
    endfunction

    task automatic send(input order_t it);
        quote_t q;
        if (burst_left == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end else begin
            @(negedge aclk);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata = '0;
        s_tdata[353:0] = {it.capitalisation, it.high_price, it.low_price, it.exchange_key,
                          it.currency_key, it.date_key, it.op};
        do @(posedge aclk); while (!s_tready);
        q = apply_order(it);
        if (it.fixed) q = it.known;
        pending_quotes.insert(pending_quotes.size(), q);
        if (it.op == OP_LOAD) loads_sent++;
        else queries_sent++;
        if (q.sum_saturated) n_saturated++;
        if (q.status == ST_FULL) n_full++;
    endtask

    function automatic order_t row(input logic [2:0] op, input logic [63:0] d,
                                   input logic [63:0] c, input logic [63:0] e,
                                   input logic [47:0] lo, input logic [47:0] hi,
                                   input logic [62:0] cap, input bit fixed,
                                   input logic [1:0] st, input logic [47:0] pf,
                                   input logic [47:0] ps, input logic [62:0] amt,
                                   input logic sat);
        order_t it;
        it.op = op;
        it.date_key = d;
        it.currency_key = c;
        it.exchange_key = e;
        it.low_price = lo;
        it.high_price = hi;
        it.capitalisation = cap;
        it.fixed = fixed;
        it.known = {st, pf, ps, amt, sat};
        return it;
    endfunction

    // receiver: alternating stretches of always-ready and random stalls, plus one long hold
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold > 0) begin
                m_tready = 1'b0;
                long_hold--;
            end else if ((cycles / 64) % 2 == 0) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        quote_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.price_first = m_tdata[49:2];
            got.price_second = m_tdata[97:50];
            got.amount = m_tdata[160:98];
            got.sum_saturated = m_tdata[161];
            if (pending_quotes.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
            end else begin
                want = pending_quotes.pop_front();
                checked++;
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                    errors++;
                end
                if (got.price_first !== want.price_first) begin
                    $display("%0t: price_first expected %h actual %h", $time,
                             want.price_first, got.price_first);
                    errors++;
                end
                if (got.price_second !== want.price_second) begin
                    $display("%0t: price_second expected %h actual %h", $time,
                             want.price_second, got.price_second);
                    errors++;
                end
                if (got.amount !== want.amount) begin
                    $display("%0t: amount expected %h actual %h", $time,
                             want.amount, got.amount);
                    errors++;
                end
                if (got.sum_saturated !== want.sum_saturated) begin
                    $display("%0t: sum_saturated expected %b actual %b", $time,
                             want.sum_saturated, got.sum_saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT && !done) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_quotes.size());
            $display("sorted_record_range_query_core_test: FAIL");
            $finish;
        end
    end

    initial begin
        order_t rows[$];
        order_t it;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        key_pool[0] = K0;
        key_pool[1] = K1;
        key_pool[2] = KA;
        key_pool[3] = KB;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty table, spare opcodes, duplicates, extremes, saturation
        rows.insert(rows.size(), row(OP_LOOKUP, K0, K0, K0, 0, 0, 0, 1, ST_NONE, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_MAX, K0, K0, K0, 0, 0, 0, 1, ST_NONE, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_MIN, K1, K1, K1, 0, 0, 0, 1, ST_NONE, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_SUM, K0, K0, K0, 0, 0, 0, 1, ST_NONE, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_SPARE5, K1, K1, K1, PRICE_MAX, PRICE_MAX, CAP_MAX,
                                     1, ST_NONE, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_SPARE6, K0, K0, K0, 0, 0, 0, 1, ST_NONE, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_SPARE7, K0, K0, K0, 0, 0, 0, 1, ST_NONE, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_LOAD, K0, K0, K0, 0, PRICE_MAX, CAP_MAX,
                                     1, ST_OK, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_LOAD, K0, K0, K0, 1, 2, 1, 1, ST_OK, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_LOOKUP, K0, K0, K0, 0, 0, 0,
                                     1, ST_OK, 0, PRICE_MAX, CAP_MAX, 0));
        rows.insert(rows.size(), row(OP_SUM, K0, KA, K0, 0, 0, 0, 1, ST_OK, 0, 0, CAP_MAX, 1));
        rows.insert(rows.size(), row(OP_LOAD, K1, K1, K1, PRICE_MAX, 0, 0,
                                     1, ST_OK, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_MAX, K0, K0, KB, 0, 0, 0,
                                     1, ST_OK, PRICE_MAX, 0, 0, 0));
        rows.insert(rows.size(), row(OP_MIN, K0, K0, KB, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_MIN, K1, K1, K0, 0, 0, 0,
                                     1, ST_OK, PRICE_MAX, 0, 0, 0));
        rows.insert(rows.size(), row(OP_LOOKUP, K1, K1, K1, 0, 0, 0,
                                     1, ST_OK, PRICE_MAX, 0, 0, 0));
        rows.insert(rows.size(), row(OP_SUM, K1, K0, K1, 0, 0, 0, 1, ST_OK, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_LOOKUP, K0, K1, K0, 0, 0, 0, 1, ST_NONE, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_LOAD, KA, KB, KA, 48'h1_0000, 48'h2_8000, 5,
                                     0, ST_OK, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_LOAD, KA, KB, KB, 48'h0_8000, 48'h3_0000, 7,
                                     0, ST_OK, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_MAX, KA, KB, K0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_MIN, KA, KB, K0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_SUM, KA, K0, KB, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0));
        rows.insert(rows.size(), row(OP_MAX, KA, KA, K0, 0, 0, 0, 1, ST_NONE, 0, 0, 0, 0));
        foreach (rows[i]) send(rows[i]);

        // random mix, table kept small so scans stay short
        for (int n = 0; n < 420; n++) begin
            if (n == 300) long_hold = 3000;
            if ((loads_sent < 200 && $urandom_range(0, 9) < 3) || $urandom_range(0, 32) == 0)
                it = random_order(OP_LOAD);
            else
                it = random_order(random_query_op());
            send(it);
        end

        // fill the table, then hit it with queries and loads while full
        while (loads_sent < DEPTH + 4) begin
            if (loads_sent % 128 == 0) send(random_order(random_query_op()));
            send(random_order(OP_LOAD));
        end
        for (int n = 0; n < 8; n++) send(random_order(3'($urandom_range(1, 4))));
        send(random_order(OP_LOAD));

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_quotes.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        done = 1;
        $display("covered %0d loads (%0d refused when full) and %0d queries, %0d words checked",
                 loads_sent, n_full, queries_sent, checked);
        $display("saturated cap sums seen: %0d, records held at the end: %0d",
                 n_saturated, rec_count);
        if (errors == 0 && pending_quotes.size() == 0) begin
            $display("sorted_record_range_query_core_test: PASS");
        end else begin
            $display("sorted_record_range_query_core_test: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
src/srrq_pkg.sv
src/srrq_ctrl.sv
src/srrq_dp.sv
src/sorted_record_range_query_core.sv
tb/sorted_record_range_query_core_test.sv
